// ===== hdl/nab_pkg.sv =====
package nab_pkg;

	localparam int MAX_OUT = 9;
	localparam int HELD_DEPTH = 3;

	localparam logic [4:0] TYPE_MASK = 5'h1f;
	localparam logic [4:0] KIND_SPS = 5'd7;
	localparam logic [4:0] KIND_PPS = 5'd8;

	localparam logic [7:0] ESC_BYTE = 8'h03;
	localparam logic [7:0] ESC_LIMIT = 8'd3;
	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_ONE = 8'h01;

	localparam logic [15:0] LEN_MAX = 16'hffff;
	localparam logic [2:0] IDX_SAT = 3'd4;
	localparam logic [1:0] ZRUN_MAX = 2'd2;

	typedef logic [7:0] nab_byte_t;
	typedef logic [3:0] nab_cnt_t;

	// One input item's worth of output bytes, in order.
	typedef struct packed {
		nab_byte_t [MAX_OUT-1:0] bytes;
		nab_cnt_t count;
		logic unit_end;
		logic changed;
	} nab_job_t;

endpackage

// ===== hdl/nab_stream_if.sv =====
interface nab_in_if import nab_pkg::*; ();
	logic valid;
	logic ready;
	nab_byte_t nal_byte;
	logic nal_first;
	logic nal_end;
	logic frame_first;

	modport source (output valid, output nal_byte, output nal_first, output nal_end,
		output frame_first, input ready);
	modport sink (input valid, input nal_byte, input nal_first, input nal_end,
		input frame_first, output ready);
endinterface

interface nab_out_if import nab_pkg::*; ();
	logic valid;
	logic ready;
	nab_byte_t out_byte;
	logic run_last;
	logic unit_done;
	logic param_changed;

	modport source (output valid, output out_byte, output run_last, output unit_done,
		output param_changed, input ready);
	modport sink (input valid, input out_byte, input run_last, input unit_done,
		input param_changed, output ready);
endinterface

// ===== hdl/nab_front.sv =====
module nab_front import nab_pkg::*; #(
	parameter int PARAM_SET_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	nab_in_if.sink nal_in,
	output nab_job_t job,
	output logic job_valid,
	input logic job_ready
);

	localparam int AW = (PARAM_SET_BYTES > 1) ? $clog2(PARAM_SET_BYTES) : 1;
	localparam logic [15:0] PS_LIMIT = 16'(PARAM_SET_BYTES);

	function automatic logic [1:0] zr_next(logic [1:0] zr, nab_byte_t b, logic esc);
		logic [1:0] r;
		if (esc) begin
			r = (b == SC_ZERO) ? 2'd1 : 2'd0;
		end else if (b == SC_ZERO) begin
			r = (zr == ZRUN_MAX) ? ZRUN_MAX : zr + 2'd1;
		end else begin
			r = 2'd0;
		end
		return r;
	endfunction

	// Accept side: unit tracking that the store read address depends on.
	logic unit_open_q;
	logic [4:0] kind_q;
	logic [15:0] len_q;

	logic accept;
	logic first_a;
	logic [4:0] kind_a;
	logic [15:0] idx_a;
	logic ps_a;
	logic rd_ok;
	logic [AW-1:0] rd_addr;

	// Commit stage.
	logic s1_valid_q;
	logic commit;
	nab_byte_t byte_s1;
	logic first_s1;
	logic end_s1;
	logic ff_s1;
	logic [4:0] kind_s1;
	logic [15:0] idx_s1;
	logic ab_sps_s1;
	logic ab_pps_s1;
	nab_byte_t sps_rd_s1;
	nab_byte_t pps_rd_s1;

	nab_byte_t sps_mem [PARAM_SET_BYTES];
	nab_byte_t pps_mem [PARAM_SET_BYTES];
	logic sps_we;
	logic pps_we;
	logic [AW-1:0] wr_addr;

	nab_byte_t held_q [HELD_DEPTH];
	logic [2:0] bidx_q;
	logic [1:0] zrun_q;
	logic pt_q;
	logic mism_q;
	logic [15:0] sps_len_q;
	logic sps_valid_q;
	logic [15:0] pps_len_q;
	logic pps_valid_q;
	logic changed_q;
	logic start_pend_q;

	logic sps_v0, pps_v0;
	logic [15:0] sps_l0, pps_l0;
	logic changed0, pend0;
	logic [2:0] bidx0;
	logic [1:0] zr0;
	logic pt0, mism0;
	logic is_sps, is_pps, ps;
	logic cur_valid;
	logic [15:0] cur_len;
	nab_byte_t cur_rd;
	logic mism1;
	logic [15:0] len1;
	logic param_fire;
	logic changed1;
	logic sps_valid_n, pps_valid_n;
	logic [15:0] sps_len_n, pps_len_n;

	nab_byte_t h0, h1, h2;
	nab_byte_t [MAX_OUT-1:0] ob;
	nab_cnt_t n;
	logic pend1, pt1;
	logic [1:0] zr1, zr_h1, zr_h2;
	logic [2:0] bidx1;
	logic esc;

	assign accept = nal_in.valid && nal_in.ready;
	assign commit = s1_valid_q && ((n == '0) || job_ready);
	assign nal_in.ready = !s1_valid_q || commit;

	assign first_a = nal_in.nal_first || !unit_open_q;
	assign kind_a = first_a ? (nal_in.nal_byte[4:0] & TYPE_MASK) : kind_q;
	assign idx_a = first_a ? 16'd0 : len_q;
	assign ps_a = (kind_a == KIND_SPS) || (kind_a == KIND_PPS);
	assign rd_ok = idx_a < PS_LIMIT;
	assign rd_addr = idx_a[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_open_q <= 1'b0;
			kind_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			unit_open_q <= !nal_in.nal_end;
			kind_q <= kind_a;
			if (ps_a) begin
				len_q <= (idx_a == LEN_MAX) ? idx_a : idx_a + 16'd1;
			end else begin
				len_q <= idx_a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= nal_in.nal_byte;
			first_s1 <= first_a;
			end_s1 <= nal_in.nal_end;
			ff_s1 <= nal_in.frame_first;
			kind_s1 <= kind_a;
			idx_s1 <= idx_a;
			ab_sps_s1 <= nal_in.nal_first && unit_open_q && (kind_q == KIND_SPS);
			ab_pps_s1 <= nal_in.nal_first && unit_open_q && (kind_q == KIND_PPS);
		end
	end

	// Parameter-set stores. A write committing in the same cycle as a read of
	// the same entry is forwarded, since the read would otherwise see stale data.
	assign wr_addr = idx_s1[AW-1:0];
	assign sps_we = commit && is_sps && (idx_s1 < PS_LIMIT);
	assign pps_we = commit && is_pps && (idx_s1 < PS_LIMIT);

	always_ff @(posedge clk) begin
		if (sps_we) begin
			sps_mem[wr_addr] <= byte_s1;
		end
		if (accept && rd_ok) begin
			sps_rd_s1 <= (sps_we && (wr_addr == rd_addr)) ? byte_s1 : sps_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pps_we) begin
			pps_mem[wr_addr] <= byte_s1;
		end
		if (accept && rd_ok) begin
			pps_rd_s1 <= (pps_we && (wr_addr == rd_addr)) ? byte_s1 : pps_mem[rd_addr];
		end
	end

	// Unit start and the parameter-set comparison.
	always_comb begin
		sps_v0 = sps_valid_q && !ab_sps_s1;
		sps_l0 = ab_sps_s1 ? 16'd0 : sps_len_q;
		pps_v0 = pps_valid_q && !ab_pps_s1;
		pps_l0 = ab_pps_s1 ? 16'd0 : pps_len_q;
		changed0 = (first_s1 && ff_s1) ? 1'b0 : changed_q;
		pend0 = (first_s1 && ff_s1) ? 1'b1 : start_pend_q;
		bidx0 = first_s1 ? 3'd0 : bidx_q;
		zr0 = first_s1 ? 2'd0 : zrun_q;
		pt0 = first_s1 ? 1'b0 : pt_q;
		mism0 = first_s1 ? 1'b0 : mism_q;

		is_sps = kind_s1 == KIND_SPS;
		is_pps = kind_s1 == KIND_PPS;
		ps = is_sps || is_pps;
		cur_valid = is_sps ? sps_v0 : pps_v0;
		cur_len = is_sps ? sps_l0 : pps_l0;
		cur_rd = is_sps ? sps_rd_s1 : pps_rd_s1;

		mism1 = mism0 || (ps && cur_valid && (idx_s1 < cur_len) && (idx_s1 < PS_LIMIT)
			&& (cur_rd != byte_s1));
		len1 = (idx_s1 == LEN_MAX) ? idx_s1 : idx_s1 + 16'd1;
		param_fire = ps && end_s1 && cur_valid && (mism1 || (len1 != cur_len));
		changed1 = changed0 || param_fire;

		sps_valid_n = sps_v0;
		sps_len_n = sps_l0;
		pps_valid_n = pps_v0;
		pps_len_n = pps_l0;
		if (param_fire && is_sps) begin
			pps_valid_n = 1'b0;
			pps_len_n = 16'd0;
		end
		if (ps && end_s1) begin
			if (is_sps) begin
				sps_valid_n = 1'b1;
				sps_len_n = len1;
			end else begin
				pps_valid_n = 1'b1;
				pps_len_n = len1;
			end
		end
	end

	// Output byte list for this item.
	always_comb begin
		h0 = (bidx0 == 3'd0) ? byte_s1 : held_q[0];
		h1 = (bidx0 == 3'd1) ? byte_s1 : held_q[1];
		h2 = (bidx0 == 3'd2) ? byte_s1 : held_q[2];
		zr_h1 = zr_next(2'd0, held_q[1], 1'b0);
		zr_h2 = zr_next(zr_h1, held_q[2], 1'b0);
		ob = '0;
		n = '0;
		pend1 = pend0;
		pt1 = pt0;
		zr1 = zr0;
		bidx1 = bidx0;
		esc = 1'b0;

		if (bidx0 < 3'd3) begin
			bidx1 = bidx0 + 3'd1;
			if (end_s1) begin
				if (pend0 || ps) begin
					ob[n] = SC_ZERO;
					n = n + 4'd1;
				end
				ob[n] = SC_ZERO;
				n = n + 4'd1;
				ob[n] = SC_ZERO;
				n = n + 4'd1;
				ob[n] = SC_ONE;
				n = n + 4'd1;
				pend1 = 1'b0;
				ob[n] = h0;
				n = n + 4'd1;
				if (bidx0 >= 3'd1) begin
					ob[n] = h1;
					n = n + 4'd1;
				end
				if (bidx0 >= 3'd2) begin
					ob[n] = h2;
					n = n + 4'd1;
				end
			end
		end else if (bidx0 == 3'd3) begin
			bidx1 = IDX_SAT;
			if (held_q[0] == SC_ZERO && held_q[1] == SC_ZERO && held_q[2] == SC_ZERO
				&& byte_s1 == SC_ONE) begin
				// The unit already carries a long start code.
				pt1 = 1'b1;
				ob[0] = held_q[0];
				ob[1] = held_q[1];
				ob[2] = held_q[2];
				ob[3] = byte_s1;
				n = 4'd4;
			end else begin
				if (pend0 || ps) begin
					ob[n] = SC_ZERO;
					n = n + 4'd1;
				end
				ob[n] = SC_ZERO;
				n = n + 4'd1;
				ob[n] = SC_ZERO;
				n = n + 4'd1;
				ob[n] = SC_ONE;
				n = n + 4'd1;
				pend1 = 1'b0;
				ob[n] = held_q[0];
				n = n + 4'd1;
				ob[n] = held_q[1];
				n = n + 4'd1;
				ob[n] = held_q[2];
				n = n + 4'd1;
				esc = !end_s1 && (zr_h2 == ZRUN_MAX) && (byte_s1 < ESC_LIMIT);
				if (esc) begin
					ob[n] = ESC_BYTE;
					n = n + 4'd1;
				end
				ob[n] = byte_s1;
				n = n + 4'd1;
				zr1 = zr_next(zr_h2, byte_s1, esc);
			end
		end else begin
			if (pt0) begin
				ob[0] = byte_s1;
				n = 4'd1;
			end else begin
				esc = !end_s1 && (zr0 == ZRUN_MAX) && (byte_s1 < ESC_LIMIT);
				if (esc) begin
					ob[n] = ESC_BYTE;
					n = n + 4'd1;
				end
				ob[n] = byte_s1;
				n = n + 4'd1;
				zr1 = zr_next(zr0, byte_s1, esc);
			end
		end
	end

	assign job.bytes = ob;
	assign job.count = n;
	assign job.unit_end = end_s1;
	assign job.changed = changed1;
	assign job_valid = s1_valid_q && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
			bidx_q <= '0;
			zrun_q <= '0;
			pt_q <= 1'b0;
			mism_q <= 1'b0;
			sps_len_q <= '0;
			sps_valid_q <= 1'b0;
			pps_len_q <= '0;
			pps_valid_q <= 1'b0;
			changed_q <= 1'b0;
			start_pend_q <= 1'b1;
		end else if (commit) begin
			if (bidx0 < 3'd3) begin
				held_q[bidx0[1:0]] <= byte_s1;
			end
			bidx_q <= bidx1;
			zrun_q <= zr1;
			pt_q <= pt1;
			mism_q <= ps ? mism1 : mism0;
			sps_len_q <= sps_len_n;
			sps_valid_q <= sps_valid_n;
			pps_len_q <= pps_len_n;
			pps_valid_q <= pps_valid_n;
			changed_q <= changed1;
			start_pend_q <= pend1;
		end
	end

endmodule

// ===== hdl/nab_queue.sv =====
module nab_queue import nab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input nab_job_t push_job,
	input logic push,
	output logic full,
	output nab_job_t head,
	output logic head_valid,
	input logic pop
);

	nab_job_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	assign full = fill_q == 2'd2;
	assign head_valid = fill_q != 2'd0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/nab_back.sv =====
module nab_back import nab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input nab_job_t head,
	input logic head_valid,
	output logic pop,
	nab_out_if.source bs_out
);

	logic out_valid_q;
	nab_byte_t out_byte_q;
	logic run_last_q;
	logic unit_done_q;
	logic changed_q;
	nab_cnt_t pos_q;

	logic load;
	logic last;

	assign load = head_valid && (!out_valid_q || bs_out.ready);
	assign last = pos_q == (head.count - 4'd1);
	assign pop = load && last;

	assign bs_out.valid = out_valid_q;
	assign bs_out.out_byte = out_byte_q;
	assign bs_out.run_last = run_last_q;
	assign bs_out.unit_done = unit_done_q;
	assign bs_out.param_changed = changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q <= last ? '0 : pos_q + 4'd1;
			end else if (bs_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[pos_q];
			run_last_q <= last;
			unit_done_q <= last && head.unit_end;
			changed_q <= head.changed;
		end
	end

endmodule

// ===== hdl/nal_to_annexb_bytestream_core.sv =====
// First bytes pass the commit register, a queue slot and the output register. Throughput:
// one output byte per cycle while the output is ready; an item of at most one byte can
// be taken every cycle unless the queue is full; a longer item holds the serializer.
// A two-entry queue between classifier and serializer lets either side stall alone.
// Reset clears all control state and both parameter-set copies; the first unit after
// reset gets a four-byte start code. Store contents are not cleared.
module nal_to_annexb_bytestream_core import nab_pkg::*; #(
	parameter int PARAM_SET_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	nab_in_if.sink nal_in,
	nab_out_if.source bs_out
);

	nab_job_t job;
	logic job_valid;
	logic q_full;
	nab_job_t head;
	logic head_valid;
	logic pop;

	nab_front #(
		.PARAM_SET_BYTES(PARAM_SET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.nal_in(nal_in),
		.job(job),
		.job_valid(job_valid),
		.job_ready(!q_full)
	);

	nab_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_job(job),
		.push(job_valid && !q_full),
		.full(q_full),
		.head(head),
		.head_valid(head_valid),
		.pop(pop)
	);

	nab_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.bs_out(bs_out)
	);

endmodule

// ===== hdl/nab_checker.sv =====
module nab_checker import nab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input nab_byte_t out_byte,
	input logic run_last,
	input logic unit_done,
	input logic param_changed
);

	// A stalled output stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last)
			&& $stable(unit_done) && $stable(param_changed))
		else $error("output payload changed while stalled");

	// The end of a unit always closes the run of its item.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unit_done |-> run_last)
		else $error("unit_done without run_last");

	// The changed flag is one value for every byte of a run.
	a_flag_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=>
			!out_valid || (param_changed == $past(param_changed)))
		else $error("param_changed varies within a run");

endmodule

bind nal_to_annexb_bytestream_core nab_checker u_nab_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(bs_out.valid),
	.out_ready(bs_out.ready),
	.out_byte(bs_out.out_byte),
	.run_last(bs_out.run_last),
	.unit_done(bs_out.unit_done),
	.param_changed(bs_out.param_changed)
);

// ===== bench/nal_to_annexb_bytestream_core_tb.sv =====
`timescale 1ns / 1ps

module nal_to_annexb_bytestream_core_tb;
	import nab_pkg::*;

	localparam int PS_BYTES = 64;

	typedef struct packed {
		nab_byte_t nal_byte;
		logic nal_first;
		logic nal_end;
		logic frame_first;
		logic hold;
	} nal_item_t;

	typedef struct packed {
		nab_byte_t out_byte;
		logic run_last;
		logic unit_done;
		logic param_changed;
	} bs_result_t;

	logic clk = 1'b0;
	logic arst_n;

	nab_in_if nal_in();
	nab_out_if bs_out();

	nal_to_annexb_bytestream_core #(.PARAM_SET_BYTES(PS_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.nal_in(nal_in),
		.bs_out(bs_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	nal_item_t nal_pending_q[$];
	bs_result_t annexb_expect_q[$];
	nab_byte_t unit_buf[$];
	nab_byte_t sps_last[$];
	nab_byte_t pps_last[$];
	nab_byte_t step_bytes[$];

	int unsigned bytes_predicted = 0;
	int unsigned bytes_seen = 0;
	int unsigned items_sent = 0;
	int unsigned fail_cnt = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	nal_item_t cur_item;
	bs_result_t got_res;
	bs_result_t want_res;

	// Converter state as the testbench tracks it.
	nab_byte_t hold_b[HELD_DEPTH];
	logic [2:0] pos;
	logic [1:0] zrun;
	logic thru;
	logic [4:0] kind;
	logic [15:0] ulen;
	logic diff_seen;
	nab_byte_t sps_mem[PS_BYTES];
	nab_byte_t pps_mem[PS_BYTES];
	logic [15:0] sps_len;
	logic [15:0] pps_len;
	logic sps_ok;
	logic pps_ok;
	logic sticky;
	logic in_unit;
	logic sc_pending;

	task automatic model_reset();
		for (int i = 0; i < HELD_DEPTH; i++)
			hold_b[i] = '0;
		for (int i = 0; i < PS_BYTES; i++) begin
			sps_mem[i] = '0;
			pps_mem[i] = '0;
		end
		pos = '0;
		zrun = '0;
		thru = 1'b0;
		kind = '0;
		ulen = '0;
		diff_seen = 1'b0;
		sps_len = '0;
		pps_len = '0;
		sps_ok = 1'b0;
		pps_ok = 1'b0;
		sticky = 1'b0;
		in_unit = 1'b0;
		sc_pending = 1'b1;
	endtask

	task automatic put_out(nab_byte_t b);
		step_bytes.push_back(b);
	endtask

	// Emulation prevention: escape a byte below 3 after two zeros, unless it ends the unit.
	task automatic put_escaped(nab_byte_t b, logic ends);
		if (!ends && zrun >= ZRUN_MAX && b < ESC_LIMIT) begin
			put_out(ESC_BYTE);
			zrun = (b == SC_ZERO) ? 2'd1 : 2'd0;
		end else if (b == SC_ZERO) begin
			if (zrun < ZRUN_MAX)
				zrun = zrun + 2'd1;
		end else begin
			zrun = 2'd0;
		end
		put_out(b);
	endtask

	task automatic put_start_code();
		if (sc_pending || kind == KIND_SPS || kind == KIND_PPS)
			put_out(SC_ZERO);
		put_out(SC_ZERO);
		put_out(SC_ZERO);
		put_out(SC_ONE);
		sc_pending = 1'b0;
	endtask

	task automatic track_param_set(nab_byte_t b, logic ends);
		logic is_sps;
		logic [15:0] ref_len;
		logic ok;
		nab_byte_t stored;
		is_sps = (kind == KIND_SPS);
		ref_len = is_sps ? sps_len : pps_len;
		ok = is_sps ? sps_ok : pps_ok;
		if (ulen < PS_BYTES) begin
			stored = is_sps ? sps_mem[ulen[5:0]] : pps_mem[ulen[5:0]];
			if (ok && ulen < ref_len && stored != b)
				diff_seen = 1'b1;
			if (is_sps)
				sps_mem[ulen[5:0]] = b;
			else
				pps_mem[ulen[5:0]] = b;
		end
		if (ulen != LEN_MAX)
			ulen = ulen + 16'd1;
		if (ends) begin
			if (ok && (diff_seen || ulen != ref_len)) begin
				sticky = 1'b1;
				if (is_sps) begin
					pps_ok = 1'b0;
					pps_len = '0;
				end
			end
			if (is_sps) begin
				sps_len = ulen;
				sps_ok = 1'b1;
			end else begin
				pps_len = ulen;
				pps_ok = 1'b1;
			end
		end
	endtask

	task automatic annexb_predict(nal_item_t it);
		logic starts;
		logic [2:0] idx;
		logic last_one;
		nab_byte_t b;
		b = it.nal_byte;
		starts = it.nal_first || !in_unit;
		step_bytes.delete();
		if (starts) begin
			// A new unit cuts off an open one; an unfinished parameter set loses its copy.
			if (in_unit) begin
				if (kind == KIND_SPS) begin
					sps_ok = 1'b0;
					sps_len = '0;
				end else if (kind == KIND_PPS) begin
					pps_ok = 1'b0;
					pps_len = '0;
				end
			end
			if (it.frame_first) begin
				sc_pending = 1'b1;
				sticky = 1'b0;
			end
			in_unit = 1'b1;
			kind = b[4:0] & TYPE_MASK;
			pos = '0;
			zrun = '0;
			thru = 1'b0;
			ulen = '0;
			diff_seen = 1'b0;
		end
		if (kind == KIND_SPS || kind == KIND_PPS)
			track_param_set(b, it.nal_end);
		idx = pos;
		if (idx < 3'(HELD_DEPTH)) begin
			hold_b[idx] = b;
			pos = idx + 3'd1;
			if (it.nal_end) begin
				put_start_code();
				for (int k = 0; k <= int'(idx); k++)
					put_out(hold_b[k]);
			end
		end else if (idx == 3'(HELD_DEPTH)) begin
			pos = IDX_SAT;
			if (hold_b[0] == SC_ZERO && hold_b[1] == SC_ZERO && hold_b[2] == SC_ZERO
					&& b == SC_ONE) begin
				thru = 1'b1;
				put_out(hold_b[0]);
				put_out(hold_b[1]);
				put_out(hold_b[2]);
				put_out(b);
			end else begin
				put_start_code();
				put_out(hold_b[0]);
				put_escaped(hold_b[1], 1'b0);
				put_escaped(hold_b[2], 1'b0);
				put_escaped(b, it.nal_end);
			end
		end else if (thru) begin
			put_out(b);
		end else begin
			put_escaped(b, it.nal_end);
		end
		if (it.nal_end)
			in_unit = 1'b0;
		for (int k = 0; k < step_bytes.size(); k++) begin
			last_one = (k == step_bytes.size() - 1);
			annexb_expect_q.push_back('{out_byte: step_bytes[k], run_last: last_one,
				unit_done: last_one && it.nal_end, param_changed: sticky});
		end
		bytes_predicted += step_bytes.size();
	endtask

	task automatic note_fail(string msg);
		if (fail_cnt < 10)
			$display("%s", msg);
		fail_cnt++;
	endtask

	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic nab_byte_t rand_payload_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return SC_ZERO;
		if (r < 50)
			return 8'($urandom_range(1, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 10);
		if (r < 96)
			return $urandom_range(11, 30);
		return $urandom_range(60, 70);
	endfunction

	task automatic add_byte(nab_byte_t b, logic starts, logic ends, logic ff,
			logic hold = 1'b0);
		nal_pending_q.push_back('{nal_byte: b, nal_first: starts, nal_end: ends,
			frame_first: ff, hold: hold});
	endtask

	task automatic fill_payload(int unsigned n);
		repeat (n)
			unit_buf.push_back(rand_payload_byte());
	endtask

	task automatic push_unit(logic ff, logic mark, logic complete, logic hold);
		for (int i = 0; i < unit_buf.size(); i++)
			add_byte(unit_buf[i], (i == 0) && mark, complete && (i == unit_buf.size() - 1),
				(i == 0) ? ff : ($urandom_range(0, 19) == 0), (i == 0) && hold);
	endtask

	// Parameter sets are often resent as an exact copy of the last one, sometimes altered.
	task automatic make_param_set(logic [4:0] ps_kind);
		nab_byte_t prev[$];
		int unsigned r;
		int unsigned n;
		if (ps_kind == KIND_SPS)
			prev = sps_last;
		else
			prev = pps_last;
		r = $urandom_range(0, 99);
		unit_buf.delete();
		if (prev.size() > 0 && r < 60) begin
			unit_buf = prev;
			if (r < 15 && unit_buf.size() > 1)
				unit_buf[$urandom_range(1, unit_buf.size() - 1)] = 8'($urandom_range(0, 255));
			else if (r < 22)
				unit_buf.push_back(rand_payload_byte());
			else if (r < 28 && unit_buf.size() > 1)
				void'(unit_buf.pop_back());
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : pick_len();
			unit_buf.push_back({3'($urandom_range(0, 7)), ps_kind});
			fill_payload(n - 1);
		end
		if (ps_kind == KIND_SPS)
			sps_last = unit_buf;
		else
			pps_last = unit_buf;
	endtask

	// Driver: presents pending items, with random gaps between transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_in.valid <= 1'b0;
			nal_in.nal_byte <= '0;
			nal_in.nal_first <= 1'b0;
			nal_in.nal_end <= 1'b0;
			nal_in.frame_first <= 1'b0;
			gap_left = 0;
		end else begin
			if (nal_in.valid && nal_in.ready) begin
				annexb_predict(cur_item);
				items_sent++;
				gap_left = ((items_sent % 80) < 20) ? 0 : pick_pause();
			end
			if (!nal_in.valid || nal_in.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					nal_in.valid <= 1'b0;
				end else if (nal_pending_q.size() > 0 && (!nal_pending_q[0].hold
						|| bytes_seen >= bytes_predicted)) begin
					cur_item = nal_pending_q.pop_front();
					nal_in.valid <= 1'b1;
					nal_in.nal_byte <= cur_item.nal_byte;
					nal_in.nal_first <= cur_item.nal_first;
					nal_in.nal_end <= cur_item.nal_end;
					nal_in.frame_first <= cur_item.frame_first;
				end else begin
					nal_in.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output transfer against the oldest expected byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_out.ready <= 1'b0;
			bytes_seen <= 0;
			stall_left = 0;
		end else begin
			if (bs_out.valid && bs_out.ready) begin
				got_res = '{out_byte: bs_out.out_byte, run_last: bs_out.run_last,
					unit_done: bs_out.unit_done, param_changed: bs_out.param_changed};
				if (annexb_expect_q.size() == 0) begin
					note_fail($sformatf("unexpected output: byte %h last %b done %b chg %b",
						got_res.out_byte, got_res.run_last, got_res.unit_done,
						got_res.param_changed));
				end else begin
					want_res = annexb_expect_q.pop_front();
					if (got_res.out_byte !== want_res.out_byte
							|| got_res.run_last !== want_res.run_last
							|| got_res.unit_done !== want_res.unit_done
							|| got_res.param_changed !== want_res.param_changed)
						note_fail($sformatf({"mismatch at output %0d: want byte %h last %b ",
							"done %b chg %b, got byte %h last %b done %b chg %b"}, bytes_seen,
							want_res.out_byte, want_res.run_last, want_res.unit_done,
							want_res.param_changed, got_res.out_byte, got_res.run_last,
							got_res.unit_done, got_res.param_changed));
				end
				bytes_seen <= bytes_seen + 1;
			end
			if (stall_left > 0) begin
				stall_left--;
				bs_out.ready <= 1'b0;
			end else begin
				bs_out.ready <= 1'b1;
				if ((bytes_seen % 100) >= 25 && $urandom_range(0, 99) < 30)
					stall_left = pick_pause();
			end
		end
	end

	initial begin
		int unsigned sel;
		int unsigned rand_goal;
		int unsigned keep;
		logic ff;
		logic mark;
		logic complete;
		logic hold;
		logic first_rand;

		// The driver and the monitor set their outputs when reset asserts.
		arst_n <= 1'b0;
		model_reset();

		// A unit that already starts with a four-byte start code passes through.
		add_byte(8'h00, 1'b1, 1'b0, 1'b1);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h01, 1'b0, 1'b0, 1'b0);
		add_byte(8'hff, 1'b0, 1'b1, 1'b0);
		// One-byte unit still owes the frame's four-byte start code.
		add_byte(8'h41, 1'b1, 1'b1, 1'b0);
		// Fourth byte yields the most output; escapes, zero run after an escape, and an
		// unescaped final byte.
		add_byte(8'h65, 1'b1, 1'b0, 1'b1);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h02, 1'b0, 1'b1, 1'b0);
		// SPS: first copy, identical copy, then a changed one with a stray frame start.
		add_byte(8'h67, 1'b1, 1'b0, 1'b0);
		add_byte(8'hff, 1'b0, 1'b1, 1'b0);
		add_byte(8'h67, 1'b1, 1'b0, 1'b0);
		add_byte(8'hff, 1'b0, 1'b1, 1'b0);
		add_byte(8'h67, 1'b1, 1'b0, 1'b0);
		add_byte(8'hfe, 1'b0, 1'b1, 1'b1);
		// A byte outside any unit starts one: a one-byte PPS.
		add_byte(8'h68, 1'b0, 1'b1, 1'b0);
		// Abandoned PPS, then a new frame.
		add_byte(8'h68, 1'b1, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0, 1'b1);
		add_byte(8'h65, 1'b1, 1'b0, 1'b1);
		add_byte(8'h80, 1'b0, 1'b1, 1'b0);
		add_byte(8'h65, 1'b1, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b1, 1'b0);

		rand_goal = nal_pending_q.size() + 350;
		first_rand = 1'b1;
		while (nal_pending_q.size() < rand_goal) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				make_param_set(KIND_SPS);
			end else if (sel < 35) begin
				make_param_set(KIND_PPS);
			end else begin
				unit_buf.delete();
				if (sel < 47) begin
					unit_buf = '{SC_ZERO, SC_ZERO, SC_ZERO, SC_ONE};
					fill_payload($urandom_range(0, 6));
				end else if (sel < 53) begin
					unit_buf = '{SC_ZERO, SC_ZERO};
					fill_payload($urandom_range(1, 6));
				end else begin
					unit_buf.push_back(8'($urandom_range(0, 255)));
					fill_payload(pick_len() - 1);
				end
			end
			complete = 1'b1;
			if ($urandom_range(0, 99) < 6 && unit_buf.size() > 1) begin
				complete = 1'b0;
				keep = $urandom_range(1, unit_buf.size() - 1);
				while (unit_buf.size() > keep)
					void'(unit_buf.pop_back());
			end
			mark = ($urandom_range(0, 99) >= 5);
			ff = ($urandom_range(0, 99) < 20);
			// The sender sometimes waits until the stream has fully drained.
			hold = first_rand || ($urandom_range(0, 99) < 2);
			first_rand = 1'b0;
			push_unit(ff, mark, complete, hold);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (nal_pending_q.size() != 0 || nal_in.valid || annexb_expect_q.size() != 0);
		repeat (60) @(negedge clk);

		if (annexb_expect_q.size() != 0)
			note_fail($sformatf("%0d expected bytes never arrived", annexb_expect_q.size()));
		if (fail_cnt == 0)
			$display("nal_to_annexb_bytestream_core test passed");
		else
			$display("nal_to_annexb_bytestream_core test failed");
		$finish;
	end

	initial begin
		#(8_000_000);
		$display("nal_to_annexb_bytestream_core test failed");
		$finish;
	end

endmodule
